// File: hw/rtl/rmt_pkg.sv
// Shared widths, register indexes and interface types of the repeat message throttle.
package rmt_pkg;

  // Default number of call-site entries in the table.
  localparam int TABLE_DEPTH_DEF = 64;

  // Field widths.
  localparam int SRC_W   = 32;
  localparam int LINE_W  = 16;
  localparam int HASH_W  = 32;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int LIMIT_W = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_IMMEDIATE_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_INTERVAL = CFG_IDX_W'(1);

  localparam logic [LIMIT_W-1:0] IMMEDIATE_LIMIT_RST = LIMIT_W'(3);
  localparam logic [TIME_W-1:0]  THROTTLE_INTERVAL_RST = TIME_W'(1000);

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [SRC_W-1:0]  source;
    logic [LINE_W-1:0] line;
    logic [HASH_W-1:0] hash;
    logic [CNT_W-1:0]  repeats;
    logic [TIME_W-1:0] last_emit;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // capture the input transfer and read entry zero
    logic scan_step;  // read the next entry
    logic eval;       // register the compare and time results
    logic commit;     // load the result register and update the table
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;        // valid entry under the scan matches source and line
    logic last;       // entry under the scan is the final one
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

// File: hw/rtl/rmt_ctrl.sv
// Controller state machine: sequences accept, table scan, evaluation and commit.
module rmt_ctrl
  import rmt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.hit || st.last) begin
          state_nxt = S_EVAL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted transfer always starts a scan.
  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SCAN))
    else $error("accepted transfer did not start a scan");

  // A scan ends on a hit or at the final entry, and goes to evaluation.
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && (st.hit || st.last)) |=> (state_r == S_EVAL))
    else $error("scan did not end on hit or final entry");

  // Evaluation moves to the commit state in the cycle after it.
  a_eval_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |=> (state_r == S_DONE))
    else $error("evaluation did not move to commit");

endmodule

// File: hw/rtl/rmt_datapath.sv
// Datapath: input capture, entry memory with valid bits, evaluation and result register.
module rmt_datapath
  import rmt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            st,
  input  logic [SRC_W-1:0]   in_source_id,
  input  logic [LINE_W-1:0]  in_line_number,
  input  logic [HASH_W-1:0]  in_msg_hash,
  input  logic [TIME_W-1:0]  in_now_ms,
  input  logic [LIMIT_W-1:0] immediate_limit,
  input  logic [TIME_W-1:0]  throttle_interval_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_emit,
  output logic               out_summary_valid,
  output logic [CNT_W-1:0]   out_repeat_count,
  output logic [TIME_W-1:0]  out_elapsed_ms
);

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_DEPTH - 1);

  // Captured input transfer.
  logic [SRC_W-1:0]  src_r;
  logic [LINE_W-1:0] line_r;
  logic [HASH_W-1:0] hash_r;
  logic [TIME_W-1:0] now_r;

  // Entry storage.
  entry_t           mem [TABLE_DEPTH];
  entry_t           rd_data_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [IDXW-1:0]  fill_ptr_r;
  logic [IDXW-1:0]  fill_ptr_nxt;
  logic [IDXW-1:0]  scan_idx_r;
  logic [IDXW-1:0]  scan_idx_nxt;
  logic             rd_en;
  logic             found_r;

  // Evaluation registers.
  logic              hash_eq_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W-1:0] dt_r;
  logic              dt_ge_r;

  // Result register.
  logic              out_valid_r;
  logic              emit_r;
  logic              sum_r;
  logic [CNT_W-1:0]  rep_r;
  logic [TIME_W-1:0] ela_r;

  // Commit-stage logic.
  logic [CNT_W-1:0]  limit_ext;
  logic              within_limit;
  logic              res_emit;
  logic              res_sum;
  logic [CNT_W-1:0]  res_rep;
  logic [TIME_W-1:0] res_ela;
  entry_t            wr_data;
  logic [IDXW-1:0]   wr_addr;

  // Capture the item when the scan starts.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      src_r  <= in_source_id;
      line_r <= in_line_number;
      hash_r <= in_msg_hash;
      now_r  <= in_now_ms;
    end
  end

  // Scan address: entry zero on start, then one entry a cycle.
  assign rd_en        = cmd.start || cmd.scan_step;
  assign scan_idx_nxt = cmd.start ? '0 : scan_idx_r + IDXW'(1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem[scan_idx_nxt];
      scan_idx_r <= scan_idx_nxt;
    end
  end

  // Status of the entry under the scan.
  assign st.hit = valid_r[scan_idx_r] && (rd_data_r.source == src_r) &&
                  (rd_data_r.line == line_r);
  assign st.last     = (scan_idx_r == LAST_IDX);
  assign st.out_free = !out_valid_r || out_ready;

  // Remember whether the scan ended on a hit.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found_r <= 1'b0;
    end else if (cmd.scan_step || st.hit) begin
      found_r <= found_r || st.hit;
    end
  end

  // Evaluation: hash compare, saturating count and elapsed time.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      hash_eq_r <= (rd_data_r.hash == hash_r);
      cnt_r     <= (rd_data_r.repeats == '1) ? rd_data_r.repeats
                                             : rd_data_r.repeats + CNT_W'(1);
      dt_r      <= now_r - rd_data_r.last_emit;
      dt_ge_r   <= ((now_r - rd_data_r.last_emit) >= throttle_interval_ms);
    end
  end

  // Result and entry update.
  assign limit_ext    = {{(CNT_W - LIMIT_W){1'b0}}, immediate_limit};
  assign within_limit = (cnt_r <= limit_ext);

  always_comb begin
    res_emit = 1'b0;
    res_sum  = 1'b0;
    res_rep  = '0;
    res_ela  = '0;
    wr_data  = rd_data_r;
    wr_addr  = scan_idx_r;
    if (!found_r) begin
      // New call site takes the entry at the fill pointer.
      res_emit          = 1'b1;
      wr_addr           = fill_ptr_r;
      wr_data.source    = src_r;
      wr_data.line      = line_r;
      wr_data.hash      = hash_r;
      wr_data.repeats   = '0;
      wr_data.last_emit = now_r;
    end else if (!hash_eq_r) begin
      // Changed message restarts its count.
      res_emit          = 1'b1;
      wr_data.hash      = hash_r;
      wr_data.repeats   = '0;
      wr_data.last_emit = now_r;
    end else begin
      wr_data.repeats = cnt_r;
      if (within_limit) begin
        res_emit          = 1'b1;
        wr_data.last_emit = now_r;
      end else if (dt_ge_r) begin
        res_emit          = 1'b1;
        res_sum           = 1'b1;
        res_rep           = cnt_r - limit_ext;
        res_ela           = dt_r;
        wr_data.last_emit = now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits and the FIFO fill pointer.
  assign fill_ptr_nxt = (fill_ptr_r == LAST_IDX) ? '0 : fill_ptr_r + IDXW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fill_ptr_r <= '0;
    end else if (cmd.commit && !found_r) begin
      valid_r[fill_ptr_r] <= 1'b1;
      fill_ptr_r          <= fill_ptr_nxt;
    end
  end

  // Result register: holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      emit_r <= res_emit;
      sum_r  <= res_sum;
      rep_r  <= res_rep;
      ela_r  <= res_ela;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_emit          = emit_r;
  assign out_summary_valid = sum_r;
  assign out_repeat_count  = rep_r;
  assign out_elapsed_ms    = ela_r;

endmodule

// File: hw/rtl/repeat_message_throttle.sv
// Top level: configuration registers, controller and datapath of the repeat message throttle.
// Lookup: an accepted item is captured and the entry memory is read one entry a cycle from
// entry zero until a hit or the final entry, so a new call site scans the whole table; the
// item is then evaluated and committed, which raises out_valid once the result register is
// free, and in_ready stays low until that commit, so a stalled result also holds the input.
// Reset: synchronous, active low; clears all valid bits, the fill pointer and the
// handshake state, and restores immediate_limit to 3 and throttle_interval_ms to 1000.
module repeat_message_throttle
  import rmt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SRC_W-1:0]      in_source_id,
  input  logic [LINE_W-1:0]     in_line_number,
  input  logic [HASH_W-1:0]     in_msg_hash,
  input  logic [TIME_W-1:0]     in_now_ms,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_emit,
  output logic                  out_summary_valid,
  output logic [CNT_W-1:0]      out_repeat_count,
  output logic [TIME_W-1:0]     out_elapsed_ms,
  // Configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [LIMIT_W-1:0] imm_limit_r;
  logic [TIME_W-1:0]  interval_r;
  cmd_t               cmd;
  status_t            st;

  // Configuration registers: every write transfer is taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imm_limit_r <= IMMEDIATE_LIMIT_RST;
      interval_r  <= THROTTLE_INTERVAL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMMEDIATE_LIMIT:   imm_limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_THROTTLE_INTERVAL: interval_r  <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller.
  rmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath.
  rmt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .in_source_id         (in_source_id),
    .in_line_number       (in_line_number),
    .in_msg_hash          (in_msg_hash),
    .in_now_ms            (in_now_ms),
    .immediate_limit      (imm_limit_r),
    .throttle_interval_ms (interval_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_emit             (out_emit),
    .out_summary_valid    (out_summary_valid),
    .out_repeat_count     (out_repeat_count),
    .out_elapsed_ms       (out_elapsed_ms)
  );

endmodule
